[rtl/core/pmtu_pkg.sv]
// Shared widths, codes, register defaults and types for the path MTU probe controller.
package pmtu_pkg;

  localparam int unsigned ModeW  = 3;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned SizeW  = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Probe phases.
  localparam logic [PhaseW-1:0] PH_NONE   = 3'd0;
  localparam logic [PhaseW-1:0] PH_BASE   = 3'd1;
  localparam logic [PhaseW-1:0] PH_SEARCH = 3'd2;
  localparam logic [PhaseW-1:0] PH_ERROR  = 3'd3;
  localparam logic [PhaseW-1:0] PH_DONE   = 3'd4;

  // Event codes carried in the mode field.
  localparam logic [ModeW-1:0] EV_START   = 3'd0;
  localparam logic [ModeW-1:0] EV_ACK     = 3'd1;
  localparam logic [ModeW-1:0] EV_PTB     = 3'd2;
  localparam logic [ModeW-1:0] EV_TIMEOUT = 3'd3;
  localparam logic [ModeW-1:0] EV_RAISE   = 3'd4;
  localparam logic [ModeW-1:0] EV_TICK    = 3'd5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_MAX_MTU   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BASE_MTU  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_TRIES = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_RAISE_MS  = 2'd3;

  // Register reset values.
  localparam logic [SizeW-1:0]  MAX_MTU_RST   = 16'd1500;
  localparam logic [SizeW-1:0]  BASE_MTU_RST  = 16'd1200;
  localparam logic [CountW-1:0] MAX_TRIES_RST = 8'd3;
  localparam logic [TimeW-1:0]  RAISE_MS_RST  = 32'd300000;

  localparam logic [SizeW:0]    SIZE_STEP = 17'd64;
  localparam logic [SizeW-1:0]  SIZE_MAX  = 16'hFFFF;
  localparam logic [CountW-1:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [SizeW-1:0]  max_path_mtu;
    logic [SizeW-1:0]  base_path_mtu;
    logic [CountW-1:0] max_probe_tries;
    logic [TimeW-1:0]  raise_interval_ms;
  } pmtu_cfg_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [CountW-1:0] attempt_count;
    logic [SizeW-1:0]  probe_size;
    logic [SizeW-1:0]  effective_size;
    logic [TimeW-1:0]  raise_start_ms;
    logic              raise_armed;
  } pmtu_state_t;

  typedef struct packed {
    logic [PhaseW-1:0] probe_state;
    logic [SizeW-1:0]  confirmed_mtu;
    logic [SizeW-1:0]  next_probe_size;
    logic [CountW-1:0] tries_used;
    logic              send_probe_request;
    logic              check_connectivity;
    logic              raise_fired;
  } pmtu_result_t;

endpackage

[rtl/core/pmtu_if.sv]
// Valid/ready channel interfaces for event items and result items.
interface pmtu_in_if;
  logic                        valid;
  logic                        ready;
  logic [pmtu_pkg::ModeW-1:0]  mode;
  logic [pmtu_pkg::TimeW-1:0]  now_ms;

  modport source (output valid, output mode, output now_ms, input ready);
  modport sink   (input valid, input mode, input now_ms, output ready);
endinterface

interface pmtu_out_if;
  logic                         valid;
  logic                         ready;
  logic [pmtu_pkg::PhaseW-1:0]  probe_state;
  logic [pmtu_pkg::SizeW-1:0]   confirmed_mtu;
  logic [pmtu_pkg::SizeW-1:0]   next_probe_size;
  logic [pmtu_pkg::CountW-1:0]  tries_used;
  logic                         send_probe_request;
  logic                         check_connectivity;
  logic                         raise_fired;

  modport source (output valid, output probe_state, output confirmed_mtu,
                  output next_probe_size, output tries_used,
                  output send_probe_request, output check_connectivity,
                  output raise_fired, input ready);
  modport sink   (input valid, input probe_state, input confirmed_mtu,
                  input next_probe_size, input tries_used,
                  input send_probe_request, input check_connectivity,
                  input raise_fired, output ready);
endinterface

[rtl/core/pmtu_cfg.sv]
// Configuration register bank written through the plain write port.
module pmtu_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pmtu_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pmtu_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output pmtu_pkg::pmtu_cfg_t             cfg_o
);

  pmtu_pkg::pmtu_cfg_t cfg_q;

  // Register writes, decoded by index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_path_mtu      <= pmtu_pkg::MAX_MTU_RST;
      cfg_q.base_path_mtu     <= pmtu_pkg::BASE_MTU_RST;
      cfg_q.max_probe_tries   <= pmtu_pkg::MAX_TRIES_RST;
      cfg_q.raise_interval_ms <= pmtu_pkg::RAISE_MS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pmtu_pkg::REG_MAX_MTU:   cfg_q.max_path_mtu    <= cfg_wdata_i[pmtu_pkg::SizeW-1:0];
        pmtu_pkg::REG_BASE_MTU:  cfg_q.base_path_mtu   <= cfg_wdata_i[pmtu_pkg::SizeW-1:0];
        pmtu_pkg::REG_MAX_TRIES: cfg_q.max_probe_tries <= cfg_wdata_i[pmtu_pkg::CountW-1:0];
        pmtu_pkg::REG_RAISE_MS:  cfg_q.raise_interval_ms <= cfg_wdata_i[pmtu_pkg::TimeW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/pmtu_step.sv]
// Next-state and result logic for one event item.
module pmtu_step (
  input  pmtu_pkg::pmtu_cfg_t            cfg_i,
  input  pmtu_pkg::pmtu_state_t          state_i,
  input  logic [pmtu_pkg::ModeW-1:0]     mode_i,
  input  logic [pmtu_pkg::TimeW-1:0]     now_ms_i,
  output pmtu_pkg::pmtu_state_t          state_o,
  output pmtu_pkg::pmtu_result_t         result_o
);

  pmtu_pkg::pmtu_state_t     st;
  logic [pmtu_pkg::ModeW-1:0] ev;
  logic                      run;
  logic                      send;
  logic                      conn;
  logic                      fired;
  logic [pmtu_pkg::TimeW-1:0] deadline;
  logic [pmtu_pkg::SizeW:0]  grown;
  logic [pmtu_pkg::CountW-1:0] count_inc;

  assign deadline  = state_i.raise_start_ms + cfg_i.raise_interval_ms;
  assign grown     = {1'b0, state_i.probe_size} + pmtu_pkg::SIZE_STEP;
  assign count_inc = (state_i.attempt_count == pmtu_pkg::COUNT_MAX) ?
                     pmtu_pkg::COUNT_MAX : state_i.attempt_count + 1'b1;

  always_comb begin
    st    = state_i;
    ev    = mode_i;
    run   = 1'b0;
    send  = 1'b0;
    conn  = 1'b0;
    fired = 1'b0;

    // A tick turns into a raise event once the armed timer has expired.
    if (mode_i == pmtu_pkg::EV_TICK) begin
      if (state_i.raise_armed && (deadline < now_ms_i)) begin
        st.raise_armed    = 1'b0;
        st.raise_start_ms = '0;
        fired             = 1'b1;
        run               = 1'b1;
        ev                = pmtu_pkg::EV_RAISE;
      end
    end else if (mode_i <= pmtu_pkg::EV_RAISE) begin
      run = 1'b1;
    end

    // Event handling per phase.
    if (run) begin
      unique case (state_i.phase)
        pmtu_pkg::PH_NONE: begin
          if (ev == pmtu_pkg::EV_ACK) begin
            st.phase = pmtu_pkg::PH_BASE;
          end else if (ev == pmtu_pkg::EV_START) begin
            st.raise_armed    = 1'b0;
            st.raise_start_ms = '0;
            conn              = 1'b1;
          end
        end
        pmtu_pkg::PH_BASE: begin
          if (ev == pmtu_pkg::EV_PTB) begin
            st.phase = pmtu_pkg::PH_ERROR;
          end else if (ev == pmtu_pkg::EV_TIMEOUT) begin
            if (state_i.attempt_count < cfg_i.max_probe_tries) begin
              st.attempt_count = count_inc;
              st.probe_size    = cfg_i.base_path_mtu;
              send             = 1'b1;
            end else begin
              st.phase = pmtu_pkg::PH_ERROR;
            end
          end else if (ev == pmtu_pkg::EV_ACK) begin
            st.effective_size = state_i.probe_size;
            st.phase = (state_i.probe_size == cfg_i.max_path_mtu) ?
                       pmtu_pkg::PH_DONE : pmtu_pkg::PH_SEARCH;
          end
        end
        pmtu_pkg::PH_SEARCH: begin
          if (ev == pmtu_pkg::EV_TIMEOUT) begin
            if (state_i.attempt_count >= cfg_i.max_probe_tries) begin
              st.phase = pmtu_pkg::PH_DONE;
            end else begin
              st.attempt_count = count_inc;
              send             = 1'b1;
            end
          end else if (ev == pmtu_pkg::EV_PTB) begin
            st.phase = pmtu_pkg::PH_BASE;
          end else if (ev == pmtu_pkg::EV_ACK) begin
            st.effective_size = state_i.probe_size;
            if (state_i.probe_size >= cfg_i.max_path_mtu) begin
              st.phase = pmtu_pkg::PH_DONE;
            end else begin
              st.attempt_count = '0;
              st.probe_size    = grown[pmtu_pkg::SizeW] ? pmtu_pkg::SIZE_MAX :
                                 grown[pmtu_pkg::SizeW-1:0];
              send             = 1'b1;
            end
          end
        end
        pmtu_pkg::PH_ERROR: begin
          if (ev == pmtu_pkg::EV_ACK) begin
            st.phase = pmtu_pkg::PH_SEARCH;
          end else if (ev == pmtu_pkg::EV_TIMEOUT) begin
            st.attempt_count = count_inc;
            st.probe_size    = cfg_i.base_path_mtu;
            send             = 1'b1;
          end
        end
        pmtu_pkg::PH_DONE: begin
          if (ev == pmtu_pkg::EV_TIMEOUT) begin
            if (state_i.attempt_count >= cfg_i.max_probe_tries) begin
              st.phase = pmtu_pkg::PH_BASE;
            end else begin
              st.attempt_count = count_inc;
              st.probe_size    = cfg_i.base_path_mtu;
              send             = 1'b1;
            end
          end else if (ev == pmtu_pkg::EV_RAISE) begin
            st.phase = pmtu_pkg::PH_BASE;
          end
        end
        default: ;
      endcase
    end

    // Entry actions of the new phase.
    if (st.phase != state_i.phase) begin
      if ((st.phase == pmtu_pkg::PH_BASE) || (st.phase == pmtu_pkg::PH_ERROR)) begin
        st.probe_size    = cfg_i.base_path_mtu;
        st.attempt_count = '0;
        send             = 1'b1;
      end else if (st.phase == pmtu_pkg::PH_SEARCH) begin
        st.probe_size     = st.effective_size;
        st.attempt_count  = '0;
        send              = 1'b1;
        st.raise_start_ms = now_ms_i;
        st.raise_armed    = 1'b1;
      end else if (st.phase == pmtu_pkg::PH_DONE) begin
        st.raise_start_ms = now_ms_i;
        st.raise_armed    = 1'b1;
      end
    end
  end

  assign state_o = st;

  // The result reports the state after the item.
  assign result_o.probe_state        = st.phase;
  assign result_o.confirmed_mtu      = st.effective_size;
  assign result_o.next_probe_size    = st.probe_size;
  assign result_o.tries_used         = st.attempt_count;
  assign result_o.send_probe_request = send;
  assign result_o.check_connectivity = conn;
  assign result_o.raise_fired        = fired;

endmodule

[rtl/core/path_mtu_probe_controller.sv]
// Top level of the path MTU probe controller.
// Each event item passes from the input register to the result register; a result-side
// stall holds it in the input register. Throughput: one item per cycle unless it stalls;
// the state commits as an item enters the result register.
// Reset: asynchronous, active low; phase none, counters and sizes zero,
// raise timer disarmed, configuration registers at their default values.
module path_mtu_probe_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  pmtu_in_if.sink                        in_i,
  pmtu_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [pmtu_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pmtu_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  pmtu_pkg::pmtu_cfg_t        cfg;
  pmtu_pkg::pmtu_state_t      state_q;
  pmtu_pkg::pmtu_state_t      state_d;
  pmtu_pkg::pmtu_result_t     result_d;
  pmtu_pkg::pmtu_result_t     result_q;
  logic                       in_valid_q;
  logic [pmtu_pkg::ModeW-1:0] in_mode_q;
  logic [pmtu_pkg::TimeW-1:0] in_now_q;
  logic                       out_valid_q;
  logic                       out_load;
  logic                       in_ready;

  pmtu_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pmtu_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .mode_i   (in_mode_q),
    .now_ms_i (in_now_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Handshake: the input register refills whenever its item moves on.
  assign out_load = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !in_valid_q || out_load;
  assign in_i.ready = in_ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_mode_q <= in_i.mode;
      in_now_q  <= in_i.now_ms;
    end
  end

  // Probe state, committed as an item reaches the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (out_load) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.probe_state        = result_q.probe_state;
  assign out_o.confirmed_mtu      = result_q.confirmed_mtu;
  assign out_o.next_probe_size    = result_q.next_probe_size;
  assign out_o.tries_used         = result_q.tries_used;
  assign out_o.send_probe_request = result_q.send_probe_request;
  assign out_o.check_connectivity = result_q.check_connectivity;
  assign out_o.raise_fired        = result_q.raise_fired;

  // Once the machine has left phase none it never returns there.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase != pmtu_pkg::PH_NONE) |=> (state_q.phase != pmtu_pkg::PH_NONE))
    else $error("probe phase returned to none");

  // A connectivity check comes only from phase none and never with a probe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_q.check_connectivity) |->
      ((result_q.probe_state == pmtu_pkg::PH_NONE) && !result_q.send_probe_request))
    else $error("connectivity check outside phase none");

  // A held input item is not lost or altered while the result side stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_o.ready) |=>
      (in_valid_q && $stable(in_mode_q) && $stable(in_now_q) && $stable(state_q)))
    else $error("input item or state changed during output stall");

endmodule
